// ===== rtl/core/mrob_pkg.sv =====
package mrob_pkg;

  localparam int RING_DEPTH  = 1024;
  localparam int MAX_READERS = 8;
  localparam int READ_LIMIT  = 64;

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int RD_W   = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int CNT_W  = $clog2(MAX_READERS + 1);
  localparam int ID_W   = 32;
  localparam int BYTE_W = 8;
  localparam int MAXB_W = 7;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_REG     = 2'd2;
  localparam logic [1:0] MODE_UNREG   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic       latch;
    logic       find;
    logic       do_write;
    logic       do_reg;
    logic       do_unreg;
    logic       rd_issue;
    logic       rd_finish;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_byte;
    logic       out_last;
  } mrob_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] mode;
    logic       hit;
    logic       table_full;
    logic       at_tail;
    logic       rd_last;
    logic       out_free;
  } mrob_stat_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ===== rtl/core/mrob_ram.sv =====
module mrob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/mrob_datapath.sv =====
module mrob_datapath
  import mrob_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mrob_cmd_t         cmd,
  output mrob_stat_t        stat,
  input  logic [1:0]        in_mode,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_of_entry,
  input  logic [ID_W-1:0]   in_reader_id,
  input  logic [MAXB_W-1:0] in_max_bytes,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [BYTE_W-1:0] out_read_byte,
  output logic              out_byte_valid,
  output logic              out_last
);

  // latched transaction
  logic [1:0]        mode_r;
  logic [BYTE_W-1:0] data_r;
  logic              lmark_r;
  logic [ID_W-1:0]   id_r;
  logic [MAXB_W-1:0] maxb_r;

  logic [PTR_W-1:0]  head_r, tail_r;
  logic [CNT_W-1:0]  count_r;
  logic              stopped_r;
  logic [ID_W-1:0]   ids_r [MAX_READERS];
  logic [PTR_W-1:0]  pos_r [MAX_READERS];

  logic              hit_r;
  logic [RD_W-1:0]   idx_r;
  logic [PTR_W-1:0]  cur_r;
  logic [MAXB_W-1:0] cnt_r, lim_r;

  logic              ov_r;
  logic [1:0]        ost_r;
  logic [BYTE_W-1:0] obyte_r;
  logic              obv_r, olast_r;

  logic              hit_c;
  logic [RD_W-1:0]   idx_c;
  logic [MAXB_W-1:0] lim_c;
  logic [PTR_W-1:0]  tail_nxt, head_nxt;
  logic              full_ov;
  logic              store_c;
  logic [RD_W-1:0]   last_idx;
  logic [BYTE_W-1:0] ram_q;

  // first matching reader in the table
  always_comb begin
    hit_c = 1'b0;
    idx_c = '0;
    for (int i = MAX_READERS - 1; i >= 0; i--) begin
      if (CNT_W'(i) < count_r && ids_r[i] == id_r) begin
        hit_c = 1'b1;
        idx_c = RD_W'(i);
      end
    end
  end

  always_comb begin
    if (maxb_r == '0) begin
      lim_c = MAXB_W'(1);
    end else if (maxb_r > MAXB_W'(READ_LIMIT)) begin
      lim_c = MAXB_W'(READ_LIMIT);
    end else begin
      lim_c = maxb_r;
    end
  end

  assign store_c  = cmd.do_write && !stopped_r && data_r != '0;
  assign tail_nxt = ring_next(tail_r);
  assign head_nxt = ring_next(head_r);
  assign full_ov  = (tail_nxt == head_r);
  assign last_idx = RD_W'(count_r - CNT_W'(1));

  mrob_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (store_c),
    .wr_addr (tail_r),
    .wr_data (data_r),
    .rd_en   (cmd.rd_issue),
    .rd_addr (cur_r),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r  <= in_mode;
      data_r  <= in_data_byte;
      lmark_r <= in_last_of_entry;
      id_r    <= in_reader_id;
      maxb_r  <= in_max_bytes;
    end
    if (cmd.find) begin
      hit_r <= hit_c;
      idx_r <= idx_c;
      cur_r <= pos_r[idx_c];
      lim_r <= lim_c;
      cnt_r <= '0;
    end
    if (cmd.rd_issue) begin
      cur_r <= ring_next(cur_r);
      cnt_r <= cnt_r + MAXB_W'(1);
    end
    if (cmd.rd_finish) begin
      pos_r[idx_r] <= cur_r;
    end
    if (store_c && full_ov) begin
      for (int i = 0; i < MAX_READERS; i++) begin
        if (CNT_W'(i) < count_r && pos_r[i] == head_r) begin
          pos_r[i] <= head_nxt;
        end
      end
    end
    if (cmd.do_reg && count_r < CNT_W'(MAX_READERS)) begin
      ids_r[count_r[RD_W-1:0]] <= id_r;
      pos_r[count_r[RD_W-1:0]] <= head_r;
    end
    if (cmd.do_unreg && hit_r) begin
      ids_r[idx_r] <= ids_r[last_idx];
      pos_r[idx_r] <= pos_r[last_idx];
    end
    if (cmd.out_load) begin
      ost_r   <= cmd.out_status;
      obyte_r <= cmd.out_byte ? ram_q : '0;
      obv_r   <= cmd.out_byte;
      olast_r <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      stopped_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      if (cmd.do_write) begin
        if (stopped_r) begin
          if (lmark_r) begin
            stopped_r <= 1'b0;
          end
        end else if (data_r == '0) begin
          stopped_r <= !lmark_r;
        end else begin
          tail_r <= tail_nxt;
          if (full_ov) begin
            head_r <= head_nxt;
          end
        end
      end
      if (cmd.do_reg && count_r < CNT_W'(MAX_READERS)) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.do_unreg && hit_r) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.out_load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign stat.mode       = mode_r;
  assign stat.hit        = hit_r;
  assign stat.table_full = (count_r >= CNT_W'(MAX_READERS));
  assign stat.at_tail    = (cur_r == tail_r);
  assign stat.rd_last    = (cur_r == tail_r) || (cnt_r == lim_r);
  assign stat.out_free   = !ov_r || out_ready;

  assign out_valid      = ov_r;
  assign out_status     = ost_r;
  assign out_read_byte  = obyte_r;
  assign out_byte_valid = obv_r;
  assign out_last       = olast_r;

endmodule

// ===== rtl/core/mrob_ctrl.sv =====
module mrob_ctrl
  import mrob_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  mrob_stat_t stat,
  output mrob_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FIND  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_RDATA = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
          unique case (stat.mode)
            MODE_WRITE: begin
              cmd.do_write   = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_OK;
            end
            MODE_READ: begin
              if (!stat.hit) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_NOT_FOUND;
              end else if (stat.at_tail) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.rd_issue = 1'b1;
                state_nxt    = S_RDATA;
              end
            end
            MODE_REG: begin
              cmd.do_reg     = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_status = stat.table_full ? ST_FULL : ST_OK;
            end
            MODE_UNREG: begin
              cmd.do_unreg   = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_status = stat.hit ? ST_OK : ST_NOT_FOUND;
            end
            default: begin
            end
          endcase
        end
      end
      S_RDATA: begin
        // RAM data of the previous issue is ready; next issue overlaps the load
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_byte   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_last   = stat.rd_last;
          if (stat.rd_last) begin
            cmd.rd_finish = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/multi_reader_overwrite_ring_buffer.sv =====
// A transaction is latched in S_IDLE, looked up in S_FIND and answered in S_EXEC, which
// loads the result register once the output is free. Write, register and unregister end
// there; a read with bytes to return goes on in S_RDATA, one byte per cycle from the ring
// RAM port while out_tready stays high. One transaction is in work at a time.
// Reset (rst_n low, synchronous): ring empty, reader table empty, no entry
// being dropped, output empty. Ring contents are not cleared.
module multi_reader_overwrite_ring_buffer
  import mrob_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // data_byte[7:0], reader_id[39:8], max_bytes[46:40], zero pad
  input  logic [1:0]  in_tuser,  // mode[1:0]
  input  logic        in_tlast,  // last_of_entry
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // read_byte[7:0]
  output logic [2:0]  out_tuser, // status[1:0], byte_valid[2]
  output logic        out_tlast  // last
);

  mrob_cmd_t  cmd;
  mrob_stat_t stat;
  logic [1:0] st;
  logic       bv;

  mrob_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrob_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_tuser),
    .in_data_byte     (in_tdata[7:0]),
    .in_last_of_entry (in_tlast),
    .in_reader_id     (in_tdata[39:8]),
    .in_max_bytes     (in_tdata[46:40]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_status       (st),
    .out_read_byte    (out_tdata),
    .out_byte_valid   (bv),
    .out_last         (out_tlast)
  );

  assign out_tuser = {bv, st};

endmodule

// ===== rtl/core/mrob_checker.sv =====
module mrob_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tlast && out_tdata == 8'd0)
    else $error("status result not final or carries data");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == 2'd0)
    else $error("byte result with error status");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("transaction taken while previous one in work");

endmodule

bind multi_reader_overwrite_ring_buffer mrob_checker u_mrob_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
